// ----- hdl/slcg_pkg.sv -----
// ============================================================================
// slcg_pkg
// Shared constants, types and the table-slot helper for the shuffled
// combined linear congruential generator.
// ============================================================================
package slcg_pkg;

    // Value width of both generators, the table entries and the output.
    localparam int VAL_W = 31;

    // Shuffle table geometry. The slot helper below assumes a power-of-two depth.
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // A reseed runs eight warm-up steps before the table is filled.
    localparam int SEED_STEPS = TABLE_DEPTH + 8;
    localparam int CNT_W      = $clog2(SEED_STEPS);

    // Generator constants. Each modulus is 2^31 minus a small fold constant.
    localparam logic [15:0]      MULT_ONE = 16'd40014;
    localparam logic [VAL_W-1:0] MOD_ONE  = 31'd2147483563;
    localparam logic [7:0]       FOLD_ONE = 8'd85;
    localparam logic [15:0]      MULT_TWO = 16'd40692;
    localparam logic [VAL_W-1:0] MOD_TWO  = 31'd2147483399;
    localparam logic [7:0]       FOLD_TWO = 8'd249;

    localparam logic [VAL_W-1:0] RANGE_TOP    = 31'd2147483562;
    localparam logic [VAL_W-1:0] FIRST_RESET  = 31'd1;
    localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

    // Generator select codes for the modular multiplier.
    localparam logic GEN_ONE = 1'b0;
    localparam logic GEN_TWO = 1'b1;

    // Slot divisor is just below a power of two: SLOT_DIV = 2^SLOT_SHIFT - SLOT_GAP.
    localparam longint SLOT_DIV   = 1 + 2147483562 / TABLE_DEPTH;
    localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);
    localparam longint SLOT_GAP   = (longint'(1) << SLOT_SHIFT) - SLOT_DIV;
    localparam int     Q_W        = VAL_W - SLOT_SHIFT + 1;

    // Table port request from the controller to the table memory.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
    } tbl_req_t;

    // Table slot from the previous output: quotient by shift, one correction
    // step for the small gap, then saturation at the last entry.
    function automatic logic [IDX_W-1:0] slot_of(input logic [VAL_W-1:0] prev);
        logic [Q_W-1:0]   q;
        logic [VAL_W:0]   rem;
        logic [VAL_W-1:0] low_mask;
        low_mask = VAL_W'((longint'(1) << SLOT_SHIFT) - 1);
        q   = Q_W'(prev >> SLOT_SHIFT);
        rem = (VAL_W+1)'(prev & low_mask) + (VAL_W+1)'(q) * (VAL_W+1)'(SLOT_GAP);
        if (rem >= (VAL_W+1)'(SLOT_DIV))
        begin
            q = q + Q_W'(1);
        end
        if (q > Q_W'(TABLE_DEPTH - 1))
        begin
            q = Q_W'(TABLE_DEPTH - 1);
        end
        return IDX_W'(q);
    endfunction

endpackage

// ----- hdl/slcg_modmul.sv -----
// ============================================================================
// slcg_modmul
// Three-stage modular multiplier: constant multiply, fold of the bits above
// 2^31, and one conditional subtract of the modulus.
// ============================================================================
module slcg_modmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sel,
    input  logic                        start,
    input  logic [slcg_pkg::VAL_W-1:0]  din,
    output logic                        done,
    output logic [slcg_pkg::VAL_W-1:0]  dout
);

    localparam int P_W = slcg_pkg::VAL_W + 16;

    logic [15:0]                 mult;
    logic [7:0]                  fold;
    logic [slcg_pkg::VAL_W-1:0]  modulus;

    logic                        vld1_reg;
    logic                        vld2_reg;
    logic                        vld3_reg;
    logic [P_W-1:0]              prod_reg;
    logic [slcg_pkg::VAL_W:0]    fold_reg;
    logic [slcg_pkg::VAL_W-1:0]  res_reg;
    logic [slcg_pkg::VAL_W:0]    fold_next;
    logic [slcg_pkg::VAL_W-1:0]  res_next;

    // Constants of the selected generator.
    always_comb
    begin
        if (sel == slcg_pkg::GEN_TWO)
        begin
            mult    = slcg_pkg::MULT_TWO;
            fold    = slcg_pkg::FOLD_TWO;
            modulus = slcg_pkg::MOD_TWO;
        end
        else
        begin
            mult    = slcg_pkg::MULT_ONE;
            fold    = slcg_pkg::FOLD_ONE;
            modulus = slcg_pkg::MOD_ONE;
        end
    end

    // Since 2^31 is congruent to the fold constant, high bits fold down.
    // The folded sum stays below twice the modulus.
    always_comb
    begin
        fold_next = (slcg_pkg::VAL_W+1)'(prod_reg[slcg_pkg::VAL_W-1:0])
                  + (slcg_pkg::VAL_W+1)'(prod_reg[P_W-1:slcg_pkg::VAL_W])
                  * (slcg_pkg::VAL_W+1)'(fold);
        if (fold_reg >= {1'b0, modulus})
        begin
            res_next = slcg_pkg::VAL_W'(fold_reg - {1'b0, modulus});
        end
        else
        begin
            res_next = fold_reg[slcg_pkg::VAL_W-1:0];
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Pipeline data.
    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(din) * P_W'(mult);
        fold_reg <= fold_next;
        res_reg  <= res_next;
    end

    assign done = vld3_reg;
    assign dout = res_reg;

`ifndef SYNTHESIS
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dout < modulus))
        else $error("modmul result not reduced below the modulus");
`endif

endmodule

// ----- hdl/slcg_table.sv -----
// ============================================================================
// slcg_table
// Shuffle table memory with one write and one registered read port. Per-entry
// valid flags make unwritten entries read as zero right after reset.
// ============================================================================
module slcg_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcg_pkg::tbl_req_t          req,
    output logic [slcg_pkg::VAL_W-1:0]  rd_data
);

    logic [slcg_pkg::VAL_W-1:0]     mem [slcg_pkg::TABLE_DEPTH];
    logic [slcg_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic                           rd_valid_reg;
    logic [slcg_pkg::VAL_W-1:0]     rd_q_reg;

    // Storage array write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    // Valid flags and the flag of the last read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr)))
        else $error("table read and write hit the same entry in one cycle");
`endif

endmodule

// ----- hdl/shuffled_combined_lcg.sv -----
// ============================================================================
// shuffled_combined_lcg
// Combined two-generator LCG with a shuffle table; one random value per
// request, with an optional reseed before the draw.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   --------------------   -------------------------
//  cmd       cmd_valid / cmd_ready  command, seed_value
//  res       res_valid / res_ready  rand_word
//
//  A draw request passes from acceptance through an issue state, the modular
//  multiplier pipeline (the table and generator update happens when its
//  result arrives) and an output load into the result register; the next
//  request is taken only back in the idle state. A reseed adds 40 steps of
//  generator one, all through the same multiplier pipeline.
//  Reset is asynchronous and clears the generators to their start values and
//  all table valid flags, so the table reads as zeros; no clearing pass.
//  A new request is taken while a result still waits; the block then stalls
//  in its output stage until the result is taken.
//
module shuffled_combined_lcg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic                        command,
    input  logic [slcg_pkg::VAL_W-1:0]  seed_value,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [slcg_pkg::VAL_W-1:0]  rand_word
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SEED      = 3'd1;
    localparam logic [2:0] S_SEED_WAIT = 3'd2;
    localparam logic [2:0] S_DRAW      = 3'd3;
    localparam logic [2:0] S_DRAW_WAIT = 3'd4;
    localparam logic [2:0] S_OUT       = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [slcg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [slcg_pkg::VAL_W-1:0]  x_reg, x_next;
    logic [slcg_pkg::VAL_W-1:0]  y_reg, y_next;
    logic [slcg_pkg::VAL_W-1:0]  prev_reg, prev_next;
    logic                        res_valid_reg, res_valid_next;
    logic [slcg_pkg::VAL_W-1:0]  rand_reg, rand_next;

    logic                        mul_start;
    logic                        mul1_done, mul2_done;
    logic [slcg_pkg::VAL_W-1:0]  mul1_res, mul2_res;
    logic [slcg_pkg::IDX_W-1:0]  slot;
    logic [slcg_pkg::VAL_W-1:0]  entry;
    logic [slcg_pkg::VAL_W-1:0]  draw_val;
    logic [slcg_pkg::VAL_W-1:0]  seed_eff;
    logic                        cmd_acc;
    slcg_pkg::tbl_req_t          tbl_req;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign seed_eff  = (seed_value == '0) ? slcg_pkg::VAL_W'(1) : seed_value;
    assign slot      = slcg_pkg::slot_of(prev_reg);

    // Generator one and generator two step in parallel units.
    slcg_modmul u_mul_one (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (slcg_pkg::GEN_ONE),
        .start (mul_start),
        .din   (x_reg),
        .done  (mul1_done),
        .dout  (mul1_res)
    );

    slcg_modmul u_mul_two (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (slcg_pkg::GEN_TWO),
        .start (mul_start && (state_reg == S_DRAW)),
        .din   (y_reg),
        .done  (mul2_done),
        .dout  (mul2_res)
    );

    slcg_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (entry)
    );

    // Shuffled output: entry minus generator two, wrapped into 1..RANGE_TOP.
    always_comb
    begin
        if ({1'b0, entry} >= ({1'b0, mul2_res} + 32'd1))
        begin
            draw_val = entry - mul2_res;
        end
        else
        begin
            draw_val = slcg_pkg::VAL_W'({1'b0, entry} + {1'b0, slcg_pkg::RANGE_TOP}
                                        - {1'b0, mul2_res});
        end
    end

    // Sequencer for reseed and draw.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prev_next      = prev_reg;
        rand_next      = rand_reg;
        res_valid_next = res_valid_reg && !res_ready;
        mul_start      = 1'b0;
        tbl_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (command)
                    begin
                        x_next     = seed_eff;
                        y_next     = seed_eff;
                        cnt_next   = slcg_pkg::CNT_W'(slcg_pkg::SEED_STEPS - 1);
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end
            S_SEED:
            begin
                mul_start  = 1'b1;
                state_next = S_SEED_WAIT;
            end
            S_SEED_WAIT:
            begin
                // Each seed step lands in the table once the count is in range.
                if (mul1_done)
                begin
                    x_next = mul1_res;
                    if (cnt_reg < slcg_pkg::CNT_W'(slcg_pkg::TABLE_DEPTH))
                    begin
                        tbl_req.wr_en   = 1'b1;
                        tbl_req.wr_addr = cnt_reg[slcg_pkg::IDX_W-1:0];
                        tbl_req.wr_data = mul1_res;
                    end
                    if (cnt_reg == '0)
                    begin
                        prev_next  = mul1_res;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - slcg_pkg::CNT_W'(1);
                        state_next = S_SEED;
                    end
                end
            end
            S_DRAW:
            begin
                mul_start       = 1'b1;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = slot;
                state_next      = S_DRAW_WAIT;
            end
            S_DRAW_WAIT:
            begin
                // Replace the picked entry with the new generator one value.
                if (mul1_done)
                begin
                    x_next          = mul1_res;
                    y_next          = mul2_res;
                    prev_next       = draw_val;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = slot;
                    tbl_req.wr_data = mul1_res;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    rand_next      = prev_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            x_reg         <= slcg_pkg::FIRST_RESET;
            y_reg         <= slcg_pkg::SECOND_RESET;
            prev_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            prev_reg      <= prev_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Output value register.
    always_ff @(posedge clk)
    begin
        rand_reg <= rand_next;
    end

    assign res_valid = res_valid_reg;
    assign rand_word = rand_reg;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((rand_word != '0) && (rand_word <= slcg_pkg::RANGE_TOP)))
        else $error("random value outside 1..RANGE_TOP");

    a_mul_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul1_done |-> ((state_reg == S_SEED_WAIT) || (state_reg == S_DRAW_WAIT)))
        else $error("multiplier result arrived outside a wait state");

    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        mul2_done |-> (mul1_done && (state_reg == S_DRAW_WAIT)))
        else $error("generator two result not aligned with a draw");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> !cmd_ready)
        else $error("second request taken before the first finished");
`endif

endmodule
